@@ src/cwc_pkg.sv @@
// Shared types and constants for the congestion window controller.
// Holds the phase and action codes, register indexes and reset defaults.
// No dependencies.
package cwc_pkg;

    // Default widths of the window counters and of sequence numbers.
    localparam int WINDOW_BITS_DEFAULT = 16;
    localparam int SEQ_BITS_DEFAULT    = 32;

    // Configuration port.
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_ADDR_BITS = 1;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_INITIAL_THRESHOLD = 1'b0,
        REG_MAX_WINDOW        = 1'b1
    } cfg_reg_t;

    // Reset values of the registers, in segments.
    localparam logic [CFG_DATA_BITS-1:0] DEFAULT_THRESHOLD  = 16'd128;
    localparam logic [CFG_DATA_BITS-1:0] DEFAULT_MAX_WINDOW = 16'd1024;

    // Number of duplicate acknowledgements that signals a loss.
    localparam logic [1:0] DUP_LIMIT = 2'd3;

    // Window inflation added on entry to fast recovery.
    localparam int RECOVERY_INFLATE = 3;

    typedef enum logic [1:0] {
        PH_SLOW_START = 2'd0,
        PH_AVOIDANCE  = 2'd1,
        PH_RECOVERY   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ACT_STALE     = 3'd0,
        ACT_DUPLICATE = 3'd1,
        ACT_LOSS      = 3'd2,
        ACT_ADVANCED  = 3'd3,
        ACT_TIMEOUT   = 3'd4
    } action_t;

endpackage

@@ src/congestion_window_controller.sv @@
// Reno-style congestion window controller, counted in segments.
// Top level; depends on cwc_pkg for phase, action and register codes.
// Single module: input register, one pass of update logic, result register.

// The controller takes one event per request on the s_ channel: an
// acknowledgement with its sequence number (s_tuser low) or a retransmit
// timeout (s_tuser high). For every event it returns exactly one result on
// the m_ channel carrying the window, the slow start threshold, the phase,
// the oldest unacknowledged sequence number, the duplicate count, what the
// event did (m_tuser) and how many segments it acknowledged. A new event is
// accepted in every clock cycle while m_tready is high; each event passes
// from the input register to the result register. The state registers are
// updated in the same edge that loads the result, so a following event
// always sees the state left by the one before it. The result register and
// the input register form a two-deep pipeline, so the s_ side keeps
// accepting while a result waits, and stalls only when both stages are
// full. The max_window register is written through the cfg_ port and
// applies to the next event; writes to the initial_threshold address are
// ignored and the threshold is loaded from DEFAULT_THRESHOLD at every
// reset. The user must write configuration only while no event is in
// flight; the block itself does not enforce this.
module congestion_window_controller #(
    parameter int WINDOW_BITS = cwc_pkg::WINDOW_BITS_DEFAULT,
    parameter int SEQ_BITS    = cwc_pkg::SEQ_BITS_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,

    // Configuration write port.
    input  logic                                     cfg_we,
    input  logic [cwc_pkg::CFG_ADDR_BITS-1:0]        cfg_addr,
    input  logic [cwc_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,

    // Event requests.
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((SEQ_BITS+7)/8)*8-1:0]            s_tdata,  // ack_seq, zero padded
    input  logic                                     s_tuser,  // mode

    // Result requests.
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // From bit 0 up: window_size, threshold, phase, window_base, dup_count,
    // advanced_by, zero padding.
    output logic [((2*WINDOW_BITS+2*SEQ_BITS+4+7)/8)*8-1:0] m_tdata,
    output logic [2:0]                               m_tuser   // action
);
    import cwc_pkg::*;

    localparam int OUT_TDATA_BITS = ((2*WINDOW_BITS + 2*SEQ_BITS + 4 + 7) / 8) * 8;
    localparam int CMP_BITS       = (WINDOW_BITS > SEQ_BITS) ? WINDOW_BITS : SEQ_BITS;
    localparam logic [WINDOW_BITS-1:0] WIN_ONES = '1;

    // Grows a window by inc segments, saturating at the ceiling. A window
    // already at or above the ceiling stays where it is.
    function automatic logic [WINDOW_BITS-1:0] grow(
        input logic [WINDOW_BITS-1:0] w,
        input logic [WINDOW_BITS-1:0] cap,
        input logic [CMP_BITS-1:0]    inc
    );
        logic [CMP_BITS-1:0] room;
        logic [CMP_BITS-1:0] sum;
        room = CMP_BITS'(cap - w);
        sum  = CMP_BITS'(w) + inc;
        if (w >= cap) begin
            grow = w;
        end else if (inc >= room) begin
            grow = cap;
        end else begin
            grow = WINDOW_BITS'(sum);
        end
    endfunction

    // Input stage.
    logic                   in_valid_reg;
    logic                   mode_reg;
    logic [SEQ_BITS-1:0]    ack_reg;

    // Result stage.
    logic                   out_valid_reg;
    logic [WINDOW_BITS-1:0] res_window_reg;
    logic [WINDOW_BITS-1:0] res_thresh_reg;
    logic [1:0]             res_phase_reg;
    logic [SEQ_BITS-1:0]    res_base_reg;
    logic [1:0]             res_dup_reg;
    action_t                res_action_reg;
    logic [SEQ_BITS-1:0]    res_adv_reg;

    // Controller state.
    logic [WINDOW_BITS-1:0] max_window_reg;
    logic [WINDOW_BITS-1:0] cwnd_reg,   cwnd_next;
    logic [WINDOW_BITS-1:0] thresh_reg, thresh_next;
    phase_t                 phase_reg,  phase_next;
    logic [1:0]             dup_reg,    dup_next;
    logic [WINDOW_BITS-1:0] acc_reg,    acc_next;
    logic [SEQ_BITS-1:0]    base_reg,   base_next;
    action_t                action_next;
    logic [SEQ_BITS-1:0]    adv_next;

    logic                   advance;
    logic [WINDOW_BITS-1:0] cap;

    // The input stage moves forward when the result stage is empty or is
    // being drained in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // A ceiling of zero behaves as one segment.
    assign cap = (max_window_reg == '0) ? WINDOW_BITS'(1) : max_window_reg;

    always_comb begin
        logic [WINDOW_BITS-1:0] half;
        logic [WINDOW_BITS:0]   inflated;
        logic [WINDOW_BITS-1:0] grown;
        logic [WINDOW_BITS-1:0] acc_sum;
        logic [1:0]             dup_inc;

        cwnd_next   = cwnd_reg;
        thresh_next = thresh_reg;
        phase_next  = phase_reg;
        dup_next    = dup_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        action_next = ACT_STALE;
        adv_next    = '0;

        half     = cwnd_reg >> 1;
        inflated = (WINDOW_BITS+1)'(half) + (WINDOW_BITS+1)'(RECOVERY_INFLATE);
        grown    = '0;
        acc_sum  = '0;
        dup_inc  = (dup_reg < DUP_LIMIT) ? dup_reg + 2'd1 : DUP_LIMIT;

        if (mode_reg) begin
            // Timeout: halve into the threshold (at least one) and restart.
            thresh_next = (half != '0) ? half : WINDOW_BITS'(1);
            cwnd_next   = WINDOW_BITS'(1);
            dup_next    = '0;
            phase_next  = PH_SLOW_START;
            acc_next    = '0;
            action_next = ACT_TIMEOUT;
        end else if (base_reg != '0 && ack_reg == base_reg - SEQ_BITS'(1)) begin
            // Duplicate of the last acknowledged segment.
            dup_next    = dup_inc;
            action_next = ACT_DUPLICATE;
            if (dup_inc == DUP_LIMIT) begin
                action_next = ACT_LOSS;
                if (phase_reg == PH_RECOVERY) begin
                    cwnd_next = grow(cwnd_reg, cap, CMP_BITS'(1));
                end else begin
                    thresh_next = half;
                    if (inflated > (WINDOW_BITS+1)'(cap)) begin
                        cwnd_next = (cap > cwnd_reg) ? cap : cwnd_reg;
                    end else begin
                        cwnd_next = WINDOW_BITS'(inflated);
                    end
                    phase_next = PH_RECOVERY;
                end
            end
        end else if (ack_reg >= base_reg) begin
            // New data acknowledged.
            adv_next    = ack_reg - base_reg + SEQ_BITS'(1);
            base_next   = ack_reg + SEQ_BITS'(1);
            dup_next    = '0;
            action_next = ACT_ADVANCED;
            case (phase_reg)
                PH_SLOW_START: begin
                    grown     = grow(cwnd_reg, cap, CMP_BITS'(adv_next));
                    cwnd_next = grown;
                    if (grown >= thresh_reg) begin
                        phase_next = PH_AVOIDANCE;
                    end
                    acc_next = '0;
                end
                PH_AVOIDANCE: begin
                    // Saturating accumulator; one segment of growth per window.
                    if (CMP_BITS'(adv_next) >= CMP_BITS'(WIN_ONES - acc_reg)) begin
                        acc_sum = WIN_ONES;
                    end else begin
                        acc_sum = acc_reg + WINDOW_BITS'(adv_next);
                    end
                    acc_next = acc_sum;
                    if (acc_sum >= cwnd_reg) begin
                        cwnd_next = grow(cwnd_reg, cap, CMP_BITS'(1));
                        acc_next  = '0;
                    end
                end
                default: begin
                    // Leaving fast recovery deflates to the threshold.
                    cwnd_next  = (thresh_reg != '0) ? thresh_reg : WINDOW_BITS'(1);
                    acc_next   = '0;
                    phase_next = PH_AVOIDANCE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_window_reg <= WINDOW_BITS'(DEFAULT_MAX_WINDOW);
            cwnd_reg       <= WINDOW_BITS'(1);
            thresh_reg     <= WINDOW_BITS'(DEFAULT_THRESHOLD);
            phase_reg      <= PH_SLOW_START;
            dup_reg        <= '0;
            acc_reg        <= '0;
            base_reg       <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_INITIAL_THRESHOLD: begin
                        // Reset reloads the threshold from its default.
                    end
                    REG_MAX_WINDOW: begin
                        max_window_reg <= WINDOW_BITS'(cfg_wdata);
                    end
                endcase
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                cwnd_reg   <= cwnd_next;
                thresh_reg <= thresh_next;
                phase_reg  <= phase_next;
                dup_reg    <= dup_next;
                acc_reg    <= acc_next;
                base_reg   <= base_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg <= s_tuser;
            ack_reg  <= s_tdata[SEQ_BITS-1:0];
        end
        if (advance) begin
            res_window_reg <= cwnd_next;
            res_thresh_reg <= thresh_next;
            res_phase_reg  <= phase_next;
            res_base_reg   <= base_next;
            res_dup_reg    <= dup_next;
            res_action_reg <= action_next;
            res_adv_reg    <= adv_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_action_reg;
    assign m_tdata  = OUT_TDATA_BITS'({res_adv_reg, res_dup_reg, res_base_reg,
                                       res_phase_reg, res_thresh_reg, res_window_reg});

    // The window never collapses to zero segments.
    a_window_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cwnd_reg != '0)
        else $error("congestion window reached zero");

    // Fast recovery is only ever held with a saturated duplicate count.
    a_recovery_dup: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_RECOVERY |-> dup_reg == DUP_LIMIT)
        else $error("fast recovery without three duplicates");

    // A timeout result always shows a restarted window in slow start.
    a_timeout_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_action_reg == ACT_TIMEOUT |->
            res_window_reg == WINDOW_BITS'(1) && res_phase_reg == PH_SLOW_START
            && res_dup_reg == '0)
        else $error("timeout result does not restart the window");

    // Only an advancing acknowledgement reports acknowledged segments.
    a_adv_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_action_reg != ACT_ADVANCED |-> res_adv_reg == '0)
        else $error("advance count on a non-advancing event");

endmodule
